// ===== rtl/bedw_pkg.sv =====
package bedw_pkg;

    // line store geometry
    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);

    // column counter compare width, wide enough for the 11-bit width register
    localparam int CNT_W = (ADDR_W + 1 > 11) ? ADDR_W + 1 : 11;

    // window shape: five columns of five rows
    localparam int WIN_H     = 5;
    localparam int NUM_CELLS = 5;
    localparam int STORE_W   = WIN_H - 1;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_LARGE_KERNEL = 2'd0,
        CFG_OPERATION    = 2'd1,
        CFG_FRAME_WIDTH  = 2'd2,
        CFG_FRAME_HEIGHT = 2'd3
    } t_cfg_idx;

    // running and/or reduction handed from cell to cell
    typedef struct packed {
        logic all_fg;
        logic any_fg;
    } t_chain;

endpackage

// ===== rtl/bedw_line_store.sv =====
module bedw_line_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [bedw_pkg::ADDR_W-1:0]       i_waddr,
    input  logic [bedw_pkg::STORE_W-1:0]      i_wdata,
    input  logic [bedw_pkg::ADDR_W-1:0]       i_raddr,
    output logic [bedw_pkg::STORE_W-1:0]      o_rdata,
    output logic                              o_busy
);

    logic [bedw_pkg::STORE_W-1:0] r_mem [bedw_pkg::MAX_WIDTH];
    logic [bedw_pkg::STORE_W-1:0] r_rdata;
    logic                         r_busy;
    logic [bedw_pkg::ADDR_W-1:0]  r_clr_addr;
    logic                         n_busy;
    logic [bedw_pkg::ADDR_W-1:0]  n_clr_addr;

    // clearing pass sequencing
    always_comb begin
        n_busy     = r_busy;
        n_clr_addr = r_clr_addr;
        if (r_busy) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == bedw_pkg::ADDR_W'(bedw_pkg::MAX_WIDTH - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_busy     <= n_busy;
            r_clr_addr <= n_clr_addr;
        end
    end

    // write port: zeros during the clearing pass, pixel history afterwards
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

// ===== rtl/bedw_cell.sv =====
module bedw_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_shift,
    input  logic                           i_active,
    input  logic                           i_large,
    input  logic [bedw_pkg::WIN_H-1:0]     i_col,
    input  bedw_pkg::t_chain               i_chain,
    output logic [bedw_pkg::WIN_H-1:0]     o_col,
    output bedw_pkg::t_chain               o_chain
);

    logic [bedw_pkg::WIN_H-1:0] r_col;
    logic [bedw_pkg::WIN_H-1:0] row_mask;
    logic [bedw_pkg::WIN_H-1:0] masked;
    logic                       col_all;
    logic                       col_any;

    // window column held by this cell, taken from the neighbour on each item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    // reduction over the column that enters this cell with the current item
    always_comb begin
        row_mask = i_large ? {bedw_pkg::WIN_H{1'b1}} : bedw_pkg::WIN_H'(3'b111);
        masked   = i_col & row_mask;
        col_all  = (masked == row_mask);
        col_any  = |masked;
        o_chain.all_fg = i_chain.all_fg & (~i_active | col_all);
        o_chain.any_fg = i_chain.any_fg | (i_active & col_any);
    end

    assign o_col = r_col;

endmodule

// ===== rtl/binary_erosion_dilation_window.sv =====
// Binary erosion / dilation over a 3x3 or 5x5 window. Pixels of a frame that
// includes its border margin enter in row order on the slave stream; a
// nonzero byte is foreground. Each interior pixel yields one result bit,
// delivered the clock after the pixel that completes its window (radius rows
// and columns later); margin pixels yield nothing and tlast marks the last
// result of a frame. Throughput is one pixel per clock unless stalled, set by
// the read-modify-write of the line store against the row of window cells.
// After reset the line store clears all 1024 entries with s_axis_tready held
// low. The user must write the registers (index: 0 large_kernel, 1 operation,
// 2 frame_width, 3 frame_height) only while the stream is idle; not enforced.
module binary_erosion_dilation_window (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // pixel input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] result_pixel, [7:1] zero
    output logic        m_axis_tlast    // end_of_frame
);

    localparam int AW = bedw_pkg::ADDR_W;
    localparam int CW = bedw_pkg::CNT_W;
    localparam int NC = bedw_pkg::NUM_CELLS;
    localparam int WH = bedw_pkg::WIN_H;

    // configuration registers
    logic        r_large_kernel;
    logic        r_operation;
    logic [10:0] r_frame_width;
    logic [15:0] r_frame_height;

    // position counters and output register
    logic [AW-1:0] r_col;
    logic [15:0]   r_row;
    logic [AW-1:0] n_col;
    logic [15:0]   n_row;
    logic          r_m_valid;
    logic          r_m_result;
    logic          r_m_last;

    logic                          accept;
    logic                          busy;
    logic                          fg;
    logic [bedw_pkg::STORE_W-1:0]  above;
    logic [WH-1:0]                 new_col;
    logic [CW-1:0]                 width_clamped;
    logic [CW-1:0]                 col_last;
    logic [15:0]                   row_last;
    logic                          last_col;
    logic                          last_row;
    logic                          emit;
    logic [4:0]                    span;
    logic                          result;

    logic [WH-1:0]     cell_col [NC+1];
    bedw_pkg::t_chain  chain    [NC+1];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_large_kernel <= 1'b0;
            r_operation    <= 1'b0;
            r_frame_width  <= 11'd1024;
            r_frame_height <= 16'd1024;
        end else if (i_cfg_we) begin
            unique case (bedw_pkg::t_cfg_idx'(i_cfg_idx))
                bedw_pkg::CFG_LARGE_KERNEL: r_large_kernel <= i_cfg_data[0];
                bedw_pkg::CFG_OPERATION:    r_operation    <= i_cfg_data[0];
                bedw_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[10:0];
                bedw_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    assign s_axis_tready = ~busy & (~r_m_valid | m_axis_tready);
    assign accept        = s_axis_tvalid & s_axis_tready;

    // frame geometry in use
    always_comb begin
        width_clamped = CW'(r_frame_width);
        if (width_clamped < CW'(3)) begin
            width_clamped = CW'(3);
        end
        if (width_clamped > CW'(bedw_pkg::MAX_WIDTH)) begin
            width_clamped = CW'(bedw_pkg::MAX_WIDTH);
        end
        col_last = width_clamped - CW'(1);
        row_last = (r_frame_height < 16'd3) ? 16'd2 : r_frame_height - 16'd1;
        last_col = CW'(r_col) >= col_last;
        last_row = r_row >= row_last;
    end

    // next position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? 16'd0 : r_row + 16'd1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line store, read one item ahead at the next column
    bedw_line_store u_line_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata (new_col[bedw_pkg::STORE_W-1:0]),
        .i_raddr (n_col),
        .o_rdata (above),
        .o_busy  (busy)
    );

    // newest window column: current pixel under the four rows above
    assign fg      = |s_axis_tdata;
    assign new_col = {above, fg};

    // row of window cells, newest column first
    assign cell_col[0]     = new_col;
    assign chain[0].all_fg = 1'b1;
    assign chain[0].any_fg = 1'b0;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        bedw_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (accept),
            .i_active (r_large_kernel | (k < 3)),
            .i_large  (r_large_kernel),
            .i_col    (cell_col[k]),
            .i_chain  (chain[k]),
            .o_col    (cell_col[k+1]),
            .o_chain  (chain[k+1])
        );
    end

    // interior test and result select
    assign span   = r_large_kernel ? 5'd4 : 5'd2;
    assign emit   = (r_row >= 16'(span)) & (CW'(r_col) >= CW'(span));
    assign result = r_operation ? chain[NC].any_fg : chain[NC].all_fg;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (accept & emit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept & emit) begin
            r_m_result <= result;
            r_m_last   <= last_col & last_row;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {7'd0, r_m_result};
    assign m_axis_tlast  = r_m_last;

endmodule
